FILE: src/sbio_pkg.sv
// Package for the system bus I/O decode block: command codes, I/O register
// addresses, result codes, the result record and the memory map check.
// Depends on nothing; system_bus_io_decode uses it by scoped names.

package sbio_pkg;

	// Memory geometry: 64 KiB held as 16-bit words.
	localparam int MEM_WORDS = 32768;
	localparam int MEM_AW    = $clog2(MEM_WORDS);

	// Bus commands.
	localparam logic [2:0] CMD_RD_BYTE = 3'd0;
	localparam logic [2:0] CMD_RD_WORD = 3'd1;
	localparam logic [2:0] CMD_WR_BYTE = 3'd2;
	localparam logic [2:0] CMD_WR_WORD = 3'd3;
	localparam logic [2:0] CMD_LOAD    = 3'd4;

	// I/O register byte addresses.
	localparam logic [15:0] A_KBD_CSR      = 16'o177660;
	localparam logic [15:0] A_KBD_CSR_HI   = 16'o177661;
	localparam logic [15:0] A_KBD_DATA     = 16'o177662;
	localparam logic [15:0] A_KBD_DATA_HI  = 16'o177663;
	localparam logic [15:0] A_SCROLL       = 16'o177664;
	localparam logic [15:0] A_SCROLL_HI    = 16'o177665;
	localparam logic [15:0] A_TMR_COUNT    = 16'o177710;
	localparam logic [15:0] A_TMR_COUNT_HI = 16'o177711;
	localparam logic [15:0] A_TMR_CTRL     = 16'o177712;
	localparam logic [15:0] A_TMR_CTRL_HI  = 16'o177713;
	localparam logic [15:0] A_TMR_SPARE    = 16'o177714;
	localparam logic [15:0] A_TMR_SPARE_HI = 16'o177715;
	localparam logic [15:0] A_SYS          = 16'o177716;
	localparam logic [15:0] A_SYS_HI       = 16'o177717;

	// The keyboard status word lives in a register, not in the RAM.
	localparam logic [MEM_AW-1:0] KBD_WIDX = A_KBD_CSR[MEM_AW:1];

	// Masks.
	localparam logic [15:0] SCROLL_MASK  = 16'o001377;
	localparam logic [15:0] KBD_CSR_MASK = 16'o000300;
	localparam logic [15:0] KBD_DAT_MASK = 16'o000177;
	localparam logic [7:0]  BOOT_RESET   = 8'd128;

	// Timer forward codes.
	localparam logic [1:0] TMR_NONE = 2'd0;
	localparam logic [1:0] TMR_LO   = 2'd1;
	localparam logic [1:0] TMR_HI   = 2'd2;
	localparam logic [1:0] TMR_WORD = 2'd3;

	// Screen event codes.
	localparam logic [1:0] SCR_NONE   = 2'd0;
	localparam logic [1:0] SCR_MODE   = 2'd1;
	localparam logic [1:0] SCR_SCROLL = 2'd2;

	// One result record.
	typedef struct packed {
		logic [15:0] read_data;
		logic        access_error;
		logic        speaker_update;
		logic        speaker_level;
		logic [1:0]  timer_write;
		logic [15:0] timer_data;
		logic [1:0]  screen_event;
		logic        small_screen;
		logic [7:0]  scroll_delta;
		logic        video_write;
	} sbio_rsp_t;

	// Writes into ROM or unmapped space are refused.
	function automatic logic refused(input logic [15:0] a);
		return (a >= 16'o100000 && a < 16'o176560) ||
			(a >= 16'o176570 && a < 16'o177660) ||
			(a > 16'o177665 && a < 16'o177706) ||
			(a > 16'o177717);
	endfunction

endpackage

FILE: src/sbio_ifs.sv
// Handshake channels of the system bus I/O decode block: the bus access
// channel and the result channel. Each carries valid, ready and payload.

interface sbio_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [15:0] address;
	logic [15:0] write_data;
	logic [7:0]  keyboard_status;

	modport source(output valid, cmd, address, write_data, keyboard_status, input ready);
	modport sink(input valid, cmd, address, write_data, keyboard_status, output ready);
endinterface

interface sbio_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        access_error;
	logic        speaker_update;
	logic        speaker_level;
	logic [1:0]  timer_write;
	logic [15:0] timer_data;
	logic [1:0]  screen_event;
	logic        small_screen;
	logic [7:0]  scroll_delta;
	logic        video_write;

	modport source(output valid, read_data, access_error, speaker_update, speaker_level,
		timer_write, timer_data, screen_event, small_screen, scroll_delta, video_write,
		input ready);
	modport sink(input valid, read_data, access_error, speaker_update, speaker_level,
		timer_write, timer_data, screen_event, small_screen, scroll_delta, video_write,
		output ready);
endinterface

FILE: src/sbio_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; read during write of the same entry returns old data.

module sbio_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/system_bus_io_decode.sv
// System bus I/O decode: a result passes from the stage 1 registers into the result queue
// and shows on rsp from there; one access per cycle while the result queue has room,
// set by one RAM read and one RAM write per access (a write forwards to the next read).
// After reset the RAM is swept to zero, one word per cycle through all 32768 words, and
// no access is taken meanwhile; configuration writes are taken at any time.
// Depends on sbio_pkg, sbio_ifs and sbio_ram.

module system_bus_io_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata,
	sbio_req_if.sink       req,
	sbio_rsp_if.source     rsp
);

	localparam int AW = sbio_pkg::MEM_AW;

	// Clearing pass state.
	logic [AW-1:0] clr_idx_q;
	logic          clr_done_q;

	// Configuration register.
	logic [7:0] boot_hi_q;

	// Stage 1: accepted access, waiting for its RAM word.
	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic [15:0] addr_s1;
	logic [15:0] data_s1;
	logic [7:0]  kb_s1;

	// Keyboard status word and write forwarding.
	logic [15:0]   kbd_q;
	logic          fwd_valid_q;
	logic [AW-1:0] fwd_idx_q;
	logic [15:0]   fwd_data_q;

	// Result queue, two entries.
	sbio_pkg::sbio_rsp_t fifo_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;

	// RAM ports.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [15:0]   ram_rdata;

	// Stage 1 logic.
	logic [AW-1:0]       widx;
	logic                is_kbd;
	logic [15:0]         w;
	logic [7:0]          b;
	logic [7:0]          d8;
	logic [15:0]         aw;
	logic [15:0]         r;
	logic                store_en;
	logic [15:0]         store_data;
	logic                kbd_ack;
	logic                scroll_chk;
	logic [15:0]         prev_sc;
	logic [15:0]         now_sc;
	logic [15:0]         hi_word;
	logic [15:0]         lo_word;
	sbio_pkg::sbio_rsp_t res;
	logic                push;
	logic                pop;
	logic [1:0]          occ_next;

	sbio_ram #(
		.WIDTH(16),
		.DEPTH(sbio_pkg::MEM_WORDS)
	) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (req.address[AW:1]),
		.rdata (ram_rdata)
	);

	// Flow control: an access is taken only if its result will find room.
	assign push     = valid_s1;
	assign pop      = rsp.valid && rsp.ready;
	assign occ_next = count_q + {1'b0, valid_s1} - {1'b0, pop};
	assign req.ready = clr_done_q && (occ_next < 2'd2);

	// Current word: keyboard register, forwarded write or RAM data.
	assign widx   = addr_s1[AW:1];
	assign is_kbd = (widx == sbio_pkg::KBD_WIDX);
	assign w      = is_kbd ? kbd_q :
		((fwd_valid_q && fwd_idx_q == widx) ? fwd_data_q : ram_rdata);
	assign b      = addr_s1[0] ? w[15:8] : w[7:0];
	assign d8     = data_s1[7:0];
	assign aw     = {addr_s1[15:1], 1'b0};
	assign hi_word = {d8, w[7:0]};
	assign lo_word = {w[15:8], d8};

	// Decode the access and build the result and the word to store.
	always_comb begin
		res        = '0;
		r          = '0;
		store_en   = 1'b0;
		store_data = '0;
		kbd_ack    = 1'b0;
		scroll_chk = 1'b0;
		prev_sc    = '0;
		now_sc     = '0;
		unique case (cmd_s1)
			sbio_pkg::CMD_RD_BYTE: begin
				r = {8'h00, b};
				unique case (addr_s1)
					sbio_pkg::A_KBD_CSR: r = {8'h00, b} & sbio_pkg::KBD_CSR_MASK;
					sbio_pkg::A_KBD_DATA: begin
						r       = {8'h00, b} & sbio_pkg::KBD_DAT_MASK;
						kbd_ack = 1'b1;
					end
					sbio_pkg::A_SCROLL_HI: r = {8'h00, b & 8'h02};
					sbio_pkg::A_TMR_CTRL_HI: r = 16'h00FF;
					sbio_pkg::A_SYS: r = {8'h00, kb_s1};
					sbio_pkg::A_SYS_HI: r = {8'h00, boot_hi_q};
					sbio_pkg::A_KBD_CSR_HI, sbio_pkg::A_KBD_DATA_HI,
					sbio_pkg::A_TMR_SPARE, sbio_pkg::A_TMR_SPARE_HI: r = '0;
					default: r = {8'h00, b};
				endcase
				res.read_data = r;
			end
			sbio_pkg::CMD_RD_WORD: begin
				r = w;
				unique case (aw)
					sbio_pkg::A_KBD_CSR: r = w & sbio_pkg::KBD_CSR_MASK;
					sbio_pkg::A_KBD_DATA: begin
						r       = w & sbio_pkg::KBD_DAT_MASK;
						kbd_ack = 1'b1;
					end
					sbio_pkg::A_SCROLL: r = w & sbio_pkg::SCROLL_MASK;
					sbio_pkg::A_TMR_CTRL: r = w | 16'hFF00;
					sbio_pkg::A_TMR_SPARE: r = '0;
					sbio_pkg::A_SYS: r = {boot_hi_q, kb_s1};
					default: r = w;
				endcase
				res.read_data = r;
			end
			sbio_pkg::CMD_WR_BYTE: begin
				if (sbio_pkg::refused(addr_s1)) begin
					res.access_error = 1'b1;
				end else begin
					unique case (addr_s1)
						sbio_pkg::A_KBD_CSR: begin
							store_en   = 1'b1;
							store_data = {w[15:8], w[7], d8[6], 6'b0};
						end
						sbio_pkg::A_KBD_CSR_HI: begin
							store_en   = 1'b1;
							store_data = {8'h00, w[7:0]};
						end
						sbio_pkg::A_SCROLL: begin
							store_en   = 1'b1;
							store_data = lo_word;
							scroll_chk = 1'b1;
						end
						sbio_pkg::A_SCROLL_HI: begin
							store_en   = 1'b1;
							store_data = {d8 & 8'h02, w[7:0]};
							scroll_chk = 1'b1;
						end
						sbio_pkg::A_TMR_CTRL: begin
							res.timer_write = sbio_pkg::TMR_LO;
							res.timer_data  = {8'h00, d8};
						end
						sbio_pkg::A_TMR_CTRL_HI: begin
							res.timer_write = sbio_pkg::TMR_HI;
							res.timer_data  = {8'h00, d8};
						end
						sbio_pkg::A_SYS: begin
							res.speaker_update = 1'b1;
							res.speaker_level  = ~d8[6];
						end
						sbio_pkg::A_KBD_DATA, sbio_pkg::A_KBD_DATA_HI,
						sbio_pkg::A_TMR_COUNT, sbio_pkg::A_TMR_COUNT_HI,
						sbio_pkg::A_SYS_HI: store_en = 1'b0;
						default: begin
							store_en   = 1'b1;
							store_data = addr_s1[0] ? hi_word : lo_word;
						end
					endcase
					res.video_write = (addr_s1[15:14] == 2'b01);
				end
			end
			sbio_pkg::CMD_WR_WORD: begin
				if (sbio_pkg::refused(aw)) begin
					res.access_error = 1'b1;
				end else begin
					unique case (aw)
						sbio_pkg::A_KBD_CSR: begin
							store_en   = 1'b1;
							store_data = {8'h00, w[7], data_s1[6], 6'b0};
						end
						sbio_pkg::A_SCROLL: begin
							store_en   = 1'b1;
							store_data = data_s1 & sbio_pkg::SCROLL_MASK;
							scroll_chk = 1'b1;
						end
						sbio_pkg::A_TMR_CTRL: begin
							res.timer_write = sbio_pkg::TMR_WORD;
							res.timer_data  = data_s1;
						end
						sbio_pkg::A_SYS: begin
							res.speaker_update = 1'b1;
							res.speaker_level  = ~data_s1[6];
						end
						sbio_pkg::A_KBD_DATA, sbio_pkg::A_TMR_COUNT: store_en = 1'b0;
						default: begin
							store_en   = 1'b1;
							store_data = data_s1;
						end
					endcase
					res.video_write = (aw[15:14] == 2'b01);
				end
			end
			sbio_pkg::CMD_LOAD: begin
				store_en   = 1'b1;
				store_data = data_s1;
			end
			default: res = '0;
		endcase

		// Scroll register change: mode bit flip or plain scroll.
		if (scroll_chk) begin
			prev_sc = w & sbio_pkg::SCROLL_MASK;
			now_sc  = store_data & sbio_pkg::SCROLL_MASK;
			if (now_sc != prev_sc) begin
				if (now_sc[9] != prev_sc[9]) begin
					res.screen_event = sbio_pkg::SCR_MODE;
					res.small_screen = prev_sc[9];
				end else begin
					res.screen_event = sbio_pkg::SCR_SCROLL;
					res.scroll_delta = now_sc[7:0] - prev_sc[7:0];
				end
			end
		end
	end

	// RAM write port: clearing pass, else the word stored by stage 1.
	always_comb begin
		if (!clr_done_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else begin
			ram_we    = valid_s1 && store_en && !is_kbd;
			ram_waddr = widx;
			ram_wdata = store_data;
		end
	end

	// Control state, configuration and keyboard register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			clr_done_q  <= 1'b0;
			boot_hi_q   <= sbio_pkg::BOOT_RESET;
			valid_s1    <= 1'b0;
			kbd_q       <= '0;
			fwd_valid_q <= 1'b0;
			wr_ptr_q    <= 1'b0;
			rd_ptr_q    <= 1'b0;
			count_q     <= '0;
		end else begin
			if (!clr_done_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == AW'(sbio_pkg::MEM_WORDS - 1)) begin
					clr_done_q <= 1'b1;
				end
			end
			if (cfg_we) begin
				boot_hi_q <= cfg_wdata;
			end
			valid_s1 <= req.valid && req.ready;

			// Keyboard word: stores to it, and the ready clear on a data read.
			if (valid_s1 && store_en && is_kbd) begin
				kbd_q <= store_data;
			end else if (valid_s1 && kbd_ack) begin
				kbd_q[7] <= 1'b0;
			end

			fwd_valid_q <= ram_we && clr_done_q;
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= occ_next;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1  <= req.cmd;
			addr_s1 <= req.address;
			data_s1 <= req.write_data;
			kb_s1   <= req.keyboard_status;
		end
		fwd_idx_q  <= ram_waddr;
		fwd_data_q <= ram_wdata;
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	// Result channel.
	assign rsp.valid          = (count_q != 2'd0);
	assign rsp.read_data      = fifo_q[rd_ptr_q].read_data;
	assign rsp.access_error   = fifo_q[rd_ptr_q].access_error;
	assign rsp.speaker_update = fifo_q[rd_ptr_q].speaker_update;
	assign rsp.speaker_level  = fifo_q[rd_ptr_q].speaker_level;
	assign rsp.timer_write    = fifo_q[rd_ptr_q].timer_write;
	assign rsp.timer_data     = fifo_q[rd_ptr_q].timer_data;
	assign rsp.screen_event   = fifo_q[rd_ptr_q].screen_event;
	assign rsp.small_screen   = fifo_q[rd_ptr_q].small_screen;
	assign rsp.scroll_delta   = fifo_q[rd_ptr_q].scroll_delta;
	assign rsp.video_write    = fifo_q[rd_ptr_q].video_write;

`ifndef SYNTHESIS
	// No access is taken while the RAM is being cleared.
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done_q |-> !req.ready)
		else $error("access taken during clearing pass");

	// The result queue never overflows.
	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (count_q < 2'd2) || pop)
		else $error("result queue overflow");

	// A refused write changes no memory word.
	a_refused_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res.access_error) |-> !ram_we && !(store_en && is_kbd))
		else $error("refused write stored data");

	// A forwarded word is always one written in the cycle before.
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_valid_q |-> $past(valid_s1))
		else $error("forwarding without a store");
`endif

endmodule
